### src/assert_macros.svh
// Assertion macros shared by the RTL. The bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### src/pn2i_pkg.sv
`default_nettype none

package pn2i_pkg;

    // Default sizes of the table.
    localparam int DEF_TABLE_DEPTH = 128;
    localparam int DEF_NAME_BYTES  = 8;
    localparam int DEF_INODE_BITS  = 16;

    // Fixed field widths of the stream ports.
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int NAME_FIELD_W  = 64;
    localparam int INODE_FIELD_W = 16;
    localparam int S_TDATA_W     = NAME_FIELD_W + INODE_FIELD_W;
    localparam int M_TDATA_W     = INODE_FIELD_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOOKUP = 2'd0,
        FN_ADD    = 2'd1,
        FN_REMOVE = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;         // Latch the accepted item and rewind the walk index.
        logic    add_write;    // Append the latched entry at the end of the table.
        logic    scan_step;    // Read the next live entry for comparison.
        logic    shift_start;  // Restart the walk just above the matched entry.
        logic    shift_step;   // Move one entry down by one place.
        logic    count_dec;    // One entry was removed.
        logic    res_load;     // Load the output register.
        t_status res_status;
        logic    res_found;    // Output the inode captured on a hit.
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;        // The entry read last cycle matches the key.
        logic walk_done;  // No read pending and no live entry left to read.
        logic full;       // The table holds its maximum number of entries.
        logic out_busy;   // The output register holds a result that is not taken.
    } t_dp_stat;

endpackage

`default_nettype wire

### src/pn2i_ctrl.sv
`default_nettype none

module pn2i_ctrl
    import pn2i_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    input  wire logic [FUNC_W-1:0] i_func,
    input  wire t_dp_stat          i_stat,
    output logic                   o_s_tready,
    output t_dp_cmd                o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ADD   = 5'b00010,
        S_SCAN  = 5'b00100,
        S_SHIFT = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state  r_state, n_state;
    t_func   r_func, n_func;
    t_status r_status, n_status;
    logic    r_found, n_found;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_status = r_status;
        n_found  = r_found;
        o_cmd    = '0;
        o_cmd.res_status = r_status;
        o_cmd.res_found  = r_found;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_func     = t_func'(i_func);
                    n_status   = ST_OK;
                    n_found    = 1'b0;
                    unique case (t_func'(i_func)) inside
                        FN_LOOKUP, FN_REMOVE: n_state = S_SCAN;
                        FN_ADD:               n_state = S_ADD;
                        default:              n_state = S_RESP;
                    endcase
                end
            end
            S_ADD: begin
                if (i_stat.full) begin
                    n_status = ST_FULL;
                end else begin
                    o_cmd.add_write = 1'b1;
                end
                n_state = S_RESP;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.hit) begin
                    if (r_func == FN_LOOKUP) begin
                        n_found = 1'b1;
                        n_state = S_RESP;
                    end else begin
                        o_cmd.shift_start = 1'b1;
                        n_state = S_SHIFT;
                    end
                end else if (i_stat.walk_done) begin
                    n_status = ST_MISS;
                    n_state  = S_RESP;
                end
            end
            S_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.walk_done) begin
                    o_cmd.count_dec = 1'b1;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_stat.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_status <= n_status;
        r_found  <= n_found;
    end

endmodule

`default_nettype wire

### src/pn2i_dp.sv
`default_nettype none

module pn2i_dp
    import pn2i_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NAME_BYTES  = DEF_NAME_BYTES,
    parameter int INODE_BITS  = DEF_INODE_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_dp_cmd                  i_cmd,
    input  wire logic [NAME_FIELD_W-1:0]  i_name,
    input  wire logic [INODE_FIELD_W-1:0] i_inode,
    input  wire logic                     i_m_tready,
    output t_dp_stat                      o_stat,
    output logic                          o_m_tvalid,
    output logic [STATUS_W-1:0]           o_status,
    output logic [M_TDATA_W-1:0]          o_inode
);

    localparam int NAME_W = NAME_BYTES * 8;
    localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW     = $clog2(TABLE_DEPTH + 1);

    logic [NAME_W-1:0]     r_name_mem  [TABLE_DEPTH];
    logic [INODE_BITS-1:0] r_inode_mem [TABLE_DEPTH];

    logic [NAME_W-1:0]     r_key;
    logic [INODE_BITS-1:0] r_new_inode;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic                  r_rd_vld;
    logic [AW-1:0]         r_rd_addr;
    logic [NAME_W-1:0]     r_rd_name;
    logic [INODE_BITS-1:0] r_rd_inode;
    logic [INODE_BITS-1:0] r_found_inode;
    logic                  r_out_vld;
    t_status               r_out_status;
    logic [M_TDATA_W-1:0]  r_out_inode;

    logic                  idx_live;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [NAME_W-1:0]     wr_name;
    logic [INODE_BITS-1:0] wr_inode;
    logic                  hit;

    assign idx_live = (r_idx < r_count);
    assign rd_en    = (i_cmd.scan_step || i_cmd.shift_step) && idx_live;
    assign rd_addr  = r_idx[AW-1:0];
    assign hit      = r_rd_vld && (r_rd_name == r_key);

    // Appends write at the fill point; the shift writes each entry one place down.
    always_comb begin
        wr_en    = 1'b0;
        wr_addr  = r_count[AW-1:0];
        wr_name  = r_key;
        wr_inode = r_new_inode;
        if (i_cmd.add_write) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift_step && r_rd_vld) begin
            wr_en    = 1'b1;
            wr_addr  = r_rd_addr - AW'(1);
            wr_name  = r_rd_name;
            wr_inode = r_rd_inode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_name_mem[wr_addr]  <= wr_name;
            r_inode_mem[wr_addr] <= wr_inode;
        end
        if (rd_en) begin
            r_rd_name  <= r_name_mem[rd_addr];
            r_rd_inode <= r_inode_mem[rd_addr];
            r_rd_addr  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.load || i_cmd.shift_start) begin
                r_rd_vld <= 1'b0;
            end else begin
                r_rd_vld <= rd_en;
            end
            if (i_cmd.add_write) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.count_dec) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.res_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key       <= i_name[NAME_W-1:0];
            r_new_inode <= INODE_BITS'(i_inode);
            r_idx       <= '0;
        end else if (i_cmd.shift_start) begin
            r_idx <= CW'(r_rd_addr) + CW'(1);
        end else if (rd_en) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.scan_step && hit) begin
            r_found_inode <= r_rd_inode;
        end
        if (i_cmd.res_load) begin
            r_out_status <= i_cmd.res_status;
            r_out_inode  <= i_cmd.res_found ? M_TDATA_W'(r_found_inode) : '0;
        end
    end

    always_comb begin
        o_stat.hit       = hit;
        o_stat.walk_done = !r_rd_vld && !idx_live;
        o_stat.full      = (r_count == CW'(TABLE_DEPTH));
        o_stat.out_busy  = r_out_vld && !i_m_tready;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_status   = r_out_status;
    assign o_inode    = r_out_inode;

endmodule

`default_nettype wire

### src/packed_name_to_inode_table.sv
// Directory table that maps file names to inode numbers. A name is a key of up to
// NAME_BYTES bytes, zero padded, carried in the low bits of the 64-bit name field;
// only the low NAME_BYTES*8 bits are stored and compared. Live entries stay packed
// at the front of the table in the order they were added. A lookup (func 0) returns
// the inode of the first matching entry with status 0, or status 1 and inode 0 on a
// miss. An add (func 1) appends the entry and returns status 0, or status 2 when the
// table already holds TABLE_DEPTH entries; duplicate names are stored as new entries.
// A remove (func 2) deletes the first match and moves every later entry down by one
// place, returning status 0, or status 1 when the name is absent. Func 3 changes
// nothing and returns status 0. Every input transfer yields exactly one output
// transfer, and one item is worked on at a time. A lookup reads the table memory
// one entry per cycle. A remove walks up to the match and then shifts the later
// entries down; the walk and the shift together read every live entry through the
// single read port of the table memory. The table memory needs no clearing after
// reset: the entry count starts at zero and only entries below it are ever read.
`default_nettype none
`include "assert_macros.svh"

module packed_name_to_inode_table
    import pn2i_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int NAME_BYTES  = DEF_NAME_BYTES,
    parameter int INODE_BITS  = DEF_INODE_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request stream.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // [63:0] entry_name, [79:64] inode_in
    input  wire logic [FUNC_W-1:0]    i_s_tuser,   // [1:0] func
    // Result stream.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata,   // [15:0] inode_out
    output logic [STATUS_W-1:0]       o_m_tuser    // [1:0] status
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     s_tready;

    // The controller sequences each operation; the datapath owns the table memory,
    // the entry count and the output register.
    pn2i_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_func     (i_s_tuser),
        .i_stat     (dp_stat),
        .o_s_tready (s_tready),
        .o_cmd      (dp_cmd)
    );

    pn2i_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NAME_BYTES  (NAME_BYTES),
        .INODE_BITS  (INODE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .i_name     (i_s_tdata[NAME_FIELD_W-1:0]),
        .i_inode    (i_s_tdata[S_TDATA_W-1:NAME_FIELD_W]),
        .i_m_tready (i_m_tready),
        .o_stat     (dp_stat),
        .o_m_tvalid (o_m_tvalid),
        .o_status   (o_m_tuser),
        .o_inode    (o_m_tdata)
    );

    assign o_s_tready = s_tready;

    // After an input transfer the block is busy with that item and not ready in the next cycle.
    `ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_s_tvalid && s_tready, !s_tready)
    // A new result never overwrites one that the consumer has not taken.
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, dp_cmd.res_load, !dp_stat.out_busy)
    // An append only happens while there is room.
    `ASSERT_IMPLY(a_add_room, i_clk, i_rst_n, dp_cmd.add_write, !dp_stat.full)
    // The shift down starts only from a matching entry.
    `ASSERT_IMPLY(a_shift_on_hit, i_clk, i_rst_n, dp_cmd.shift_start, dp_stat.hit)

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

// Checks the name-to-inode directory table through its two stream ports.
// A local copy of the table follows every accepted request, and each result
// transfer is compared with the oldest outstanding prediction. A short
// directed sequence runs first. Three random phases follow, each of which
// fills the table until adds are refused and then removes entries again. The
// phases differ in how often the sender and the receiver idle.
module testbench;
    import pn2i_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    // The func encoding that the block must ignore.
    localparam logic [FUNC_W-1:0] FN_IGNORED = 2'd3;
    localparam int POOL_SIZE = 16;
    // Length of the single long receiver hold-off, in clock cycles.
    localparam int HOLD_CYCLES = 400;
    // Slack after the last result: more than a remove over a full table.
    localparam int SETTLE_CYCLES = 2 * DEPTH + 20;

    typedef struct {
        logic [FUNC_W-1:0]        func;
        logic [NAME_FIELD_W-1:0]  name;
        logic [INODE_FIELD_W-1:0] inode;
    } dir_request_t;

    typedef struct {
        t_status                  status;
        logic [INODE_FIELD_W-1:0] inode;
    } dir_result_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [S_TDATA_W-1:0]     s_tdata = '0;   // [63:0] entry_name, [79:64] inode_in
    logic [FUNC_W-1:0]        s_tuser = '0;   // [1:0] func
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [M_TDATA_W-1:0]     m_tdata;        // [15:0] inode_out
    logic [STATUS_W-1:0]      m_tuser;        // [1:0] status

    // Local copy of the directory: live entries packed at the front.
    logic [NAME_FIELD_W-1:0]  table_names[DEPTH];
    logic [INODE_FIELD_W-1:0] table_inodes[DEPTH];
    int                       table_count = 0;

    dir_request_t             request_queue[$];
    dir_result_t              expected_results[$];
    dir_request_t             offered;
    logic [NAME_FIELD_W-1:0]  name_pool[POOL_SIZE];

    int                       tx_idle_pct = 0;
    int                       rx_idle_pct = 0;
    bit                       hold_arm = 1'b0;
    int                       hold_count = 0;
    bit                       mismatch_seen = 1'b0;

    packed_name_to_inode_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Applies one request to the local table and returns the result that the
    // block must produce for it.
    function automatic dir_result_t apply_request(dir_request_t req);
        dir_result_t res;
        int          pos;
        int          i;
        res.status = ST_OK;
        res.inode = '0;
        pos = table_count;
        for (i = 0; i < table_count; i++) begin
            if (table_names[i] == req.name) begin
                pos = i;
                break;
            end
        end
        if (req.func == FN_LOOKUP) begin
            if (pos < table_count) begin
                res.inode = table_inodes[pos];
            end else begin
                res.status = ST_MISS;
            end
        end else if (req.func == FN_ADD) begin
            if (table_count >= DEPTH) begin
                res.status = ST_FULL;
            end else begin
                table_names[table_count] = req.name;
                table_inodes[table_count] = req.inode;
                table_count++;
            end
        end else if (req.func == FN_REMOVE) begin
            if (pos < table_count) begin
                // Close the gap: every later entry moves down one place.
                for (i = pos; i + 1 < table_count; i++) begin
                    table_names[i] = table_names[i + 1];
                    table_inodes[i] = table_inodes[i + 1];
                end
                table_count--;
            end else begin
                res.status = ST_MISS;
            end
        end
        return res;
    endfunction

    task automatic queue_request(logic [FUNC_W-1:0] func, logic [NAME_FIELD_W-1:0] name,
                                 logic [INODE_FIELD_W-1:0] inode);
        dir_request_t req;
        req.func = func;
        req.name = name;
        req.inode = inode;
        request_queue.push_back(req);
    endtask

    // Queues random requests with the given mix of operations. Most names
    // come from a small pool so that lookups and removes mostly hit; the rest
    // are fresh random keys that almost always miss.
    task automatic queue_random(int count, int add_pct, int lookup_pct, int remove_pct);
        int                      n;
        int                      pick;
        logic [FUNC_W-1:0]       func;
        logic [NAME_FIELD_W-1:0] name;
        for (n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < add_pct) begin
                func = FN_ADD;
            end else if (pick < add_pct + lookup_pct) begin
                func = FN_LOOKUP;
            end else if (pick < add_pct + lookup_pct + remove_pct) begin
                func = FN_REMOVE;
            end else begin
                func = FN_IGNORED;
            end
            if ($urandom_range(99) < 85) begin
                name = name_pool[$urandom_range(POOL_SIZE - 1)];
            end else begin
                name = {$urandom, $urandom};
            end
            queue_request(func, name, INODE_FIELD_W'($urandom_range(16'hFFFF)));
        end
    endtask

    // The sender holds back until the block has answered everything sent.
    task automatic wait_all_answered();
        while (request_queue.size() != 0 || s_tvalid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Driver. A request is predicted at the edge where its transfer happens,
    // and the next one is offered at the same edge, unless the sender idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_request(offered));
            end
            if (!s_tvalid || s_tready) begin
                if (request_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offered = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {offered.inode, offered.name};
                    s_tuser <= offered.func;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Counts out the long receiver hold-off once it has been armed.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_count <= 0;
        end else if (hold_arm && hold_count != HOLD_CYCLES) begin
            hold_count <= hold_count + 1;
        end
    end

    // Monitor. Each result transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        dir_result_t want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no request outstanding: status %0d inode %0h",
                           m_tuser, m_tdata);
                    mismatch_seen = 1'b1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_tuser);
                        mismatch_seen = 1'b1;
                    end
                    if (m_tdata !== want.inode) begin
                        $error("inode_out mismatch: expected %0h, actual %0h",
                               want.inode, m_tdata);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            m_tready <= !(hold_arm && hold_count != HOLD_CYCLES)
                        && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        int k;
        name_pool[0] = '0;
        name_pool[1] = '1;
        name_pool[2] = 64'h8000_0000_0000_0000;
        name_pool[3] = 64'h0000_0000_0000_0001;
        for (k = 4; k < POOL_SIZE; k++) begin
            name_pool[k] = {$urandom, $urandom};
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: misses on an empty table, the ignored func value,
        // extreme names and inodes, and a duplicate name where lookup and
        // remove must find the older entry first.
        queue_request(FN_LOOKUP, '0, '0);
        queue_request(FN_REMOVE, '1, '1);
        queue_request(FN_IGNORED, '1, '1);
        queue_request(FN_ADD, '0, '0);
        queue_request(FN_ADD, '1, 16'hFFFF);
        queue_request(FN_ADD, name_pool[5], 16'h1234);
        queue_request(FN_ADD, name_pool[5], 16'h5678);
        queue_request(FN_LOOKUP, name_pool[5], '0);
        queue_request(FN_LOOKUP, '1, '0);
        queue_request(FN_LOOKUP, '0, 16'hFFFF);
        queue_request(FN_LOOKUP, name_pool[2], '0);
        queue_request(FN_REMOVE, name_pool[5], '0);
        queue_request(FN_LOOKUP, name_pool[5], '0);
        queue_request(FN_REMOVE, name_pool[5], '0);
        queue_request(FN_LOOKUP, name_pool[5], '0);
        queue_request(FN_REMOVE, name_pool[6], '0);
        queue_request(FN_IGNORED, '0, '0);
        queue_request(FN_REMOVE, '0, '0);
        queue_request(FN_LOOKUP, '1, '0);
        queue_request(FN_REMOVE, '1, '0);
        queue_request(FN_LOOKUP, '0, '0);
        wait_all_answered();

        // Sender idles often, receiver idles more.
        tx_idle_pct = 31;
        rx_idle_pct = 66;
        queue_random(200, 80, 8, 8);
        queue_random(100, 10, 15, 70);
        wait_all_answered();

        // The other way round.
        tx_idle_pct = 66;
        rx_idle_pct = 31;
        queue_random(200, 80, 8, 8);
        queue_random(100, 10, 15, 70);
        wait_all_answered();

        // Neither side idles. The receiver first holds off for a long stretch
        // while requests keep coming, so the block backs up into its input.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_arm = 1'b1;
        queue_random(200, 80, 8, 8);
        queue_random(100, 10, 15, 70);
        wait_all_answered();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (!mismatch_seen && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
